// ===== rtl/wms_pkg.sv =====
// Shared types and constants for the weighted mean / standard deviation core.
// No dependencies.
package wms_pkg;
    localparam int STATUS_W = 2;
    // sample width on the stream and in the sample memory
    localparam int SAMPLE_BITS = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_SUM = 2'd1,
        ST_TRUNC    = 2'd2
    } status_t;

    // One loaded pair as it travels from the front end to the back end
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [15:0]            weight;
        logic                   is_last;
    } pair_t;
endpackage

// ===== rtl/wms_fifo.sv =====
// Short queue between the front end and the back end.
// Depends on wms_pkg.
module wms_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  wms_pkg::pair_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output wms_pkg::pair_t out_data
);
    import wms_pkg::*;

    pair_t      mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 3'd4);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end
endmodule

// ===== rtl/wms_back.sv =====
// Back end: stores pairs, runs both passes, the divisions and the root.
// Depends on wms_pkg.
module wms_back #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  wms_pkg::pair_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [15:0]    out_mean,
    output logic [15:0]    out_std,
    output logic [1:0]     out_status
);
    import wms_pkg::*;

    localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int WTW = CW + 16;                 // weight total
    localparam int PW  = CW + SAMPLE_BITS + 17;   // signed product sum
    localparam int DDW = SAMPLE_BITS + 2;         // deviation
    localparam int DW  = CW + 2*DDW + 16;         // deviation sum
    localparam int QW  = DW;                      // quotient width (widest)
    localparam int RW  = DW;                      // root working width

    typedef enum logic [3:0] {
        S_LOAD, S_P1_RD, S_P1_ACC, S_DIV1, S_P2_RD, S_P2_SQ, S_P2_ACC,
        S_DIV2, S_ROOT, S_OUT
    } state_t;

    logic [SAMPLE_BITS-1:0] smem [MAX_ITEMS];
    logic [15:0]            wmem [MAX_ITEMS];
    logic [SAMPLE_BITS-1:0] s_rd_reg;
    logic [15:0]            w_rd_reg;

    state_t               state_reg;
    logic [CW-1:0]        count_reg, idx_reg;
    logic                 ovf_reg;
    logic signed [PW-1:0] psum_reg;
    logic [WTW-1:0]       wtot_reg;
    logic [DW-1:0]        dsum_reg;
    logic signed [DDW:0]  mean_reg;
    logic [2*DDW-1:0]     sq_reg;
    logic                 neg_reg;
    // shared restoring divider
    logic [QW-1:0]        dnum_reg, dquo_reg;
    logic [QW:0]          drem_reg;
    logic [$clog2(QW+1)-1:0] dcnt_reg;
    // root
    logic [DW-1:0]        rv_reg, rb_reg;
    logic [RW-1:0]        rr_reg;
    logic [15:0]          mean_o_reg, std_o_reg;
    logic [1:0]           stat_reg;
    // output holding register
    logic                 out_valid_reg;
    logic [15:0]          out_mean_reg, out_std_reg;
    logic [1:0]           out_stat_reg;

    logic                  accept;
    logic signed [DDW-1:0] s_ext, dev;
    logic [DDW-1:0]        adev;
    logic [QW:0]           drem_sh;
    logic [DW:0]           rtrial;
    logic signed [SAMPLE_BITS+16:0] prod1;
    logic [2*DDW+15:0]     prod2;

    assign in_ready   = (state_reg == S_LOAD);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_mean   = out_mean_reg;
    assign out_std    = out_std_reg;
    assign out_status = out_stat_reg;

    assign s_ext   = DDW'($signed(s_rd_reg));
    assign dev     = s_ext - DDW'(mean_reg);
    assign adev    = dev[DDW-1] ? DDW'(-dev) : dev;
    assign drem_sh = {drem_reg[QW-1:0], dnum_reg[QW-1]};
    assign rtrial  = {1'b0, rr_reg} + {1'b0, rb_reg};
    assign prod1   = $signed(s_rd_reg) * $signed({1'b0, w_rd_reg});
    assign prod2   = sq_reg * w_rd_reg;

    always_ff @(posedge aclk) begin
        if (accept && count_reg < CW'(MAX_ITEMS)) begin
            smem[count_reg[AW-1:0]] <= in_data.sample[SAMPLE_BITS-1:0];
            wmem[count_reg[AW-1:0]] <= in_data.weight;
        end
        s_rd_reg <= smem[idx_reg[AW-1:0]];
        w_rd_reg <= wmem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // hold the result until it is taken; S_OUT loads a new one once the register is free or taken
            out_valid_reg <= (state_reg == S_OUT) || (out_valid_reg && !out_ready);
            case (state_reg)
                S_LOAD: if (accept) begin
                    if (count_reg < CW'(MAX_ITEMS)) count_reg <= count_reg + 1'b1;
                    else ovf_reg <= 1'b1;
                    if (in_data.is_last) begin
                        idx_reg   <= '0;
                        psum_reg  <= '0;
                        wtot_reg  <= '0;
                        state_reg <= S_P1_RD;
                    end
                end
                S_P1_RD: begin
                    // read address idx_reg settles into s_rd_reg/w_rd_reg
                    if (idx_reg == count_reg) begin
                        if (wtot_reg == '0) begin
                            mean_o_reg <= '0;
                            std_o_reg  <= '0;
                            stat_reg   <= ST_ZERO_SUM;
                            state_reg  <= S_OUT;
                        end else begin
                            neg_reg   <= psum_reg[PW-1];
                            dnum_reg  <= QW'(psum_reg[PW-1] ? -psum_reg : psum_reg);
                            drem_reg  <= '0;
                            dcnt_reg  <= '0;
                            state_reg <= S_DIV1;
                        end
                    end else begin
                        state_reg <= S_P1_ACC;
                    end
                end
                S_P1_ACC: begin
                    psum_reg  <= psum_reg + PW'(prod1);
                    wtot_reg  <= wtot_reg + WTW'(w_rd_reg);
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_P1_RD;
                end
                S_DIV1, S_DIV2: begin
                    // one quotient bit per cycle
                    if (drem_sh >= (QW+1)'(wtot_reg)) begin
                        drem_reg <= drem_sh - (QW+1)'(wtot_reg);
                        dquo_reg <= {dquo_reg[QW-2:0], 1'b1};
                    end else begin
                        drem_reg <= drem_sh;
                        dquo_reg <= {dquo_reg[QW-2:0], 1'b0};
                    end
                    dnum_reg <= dnum_reg << 1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == ($clog2(QW+1))'(QW-1)) begin
                        if (state_reg == S_DIV1) begin
                            idx_reg   <= '0;
                            dsum_reg  <= '0;
                            state_reg <= S_P2_RD;
                        end else begin
                            rv_reg    <= {dquo_reg[QW-2:0], (drem_sh >= (QW+1)'(wtot_reg))};
                            rr_reg    <= '0;
                            rb_reg    <= DW'(1) << (2*((DW-1)/2));
                            state_reg <= S_ROOT;
                        end
                    end
                end
                S_P2_RD: begin
                    if (dcnt_reg != '0) begin
                        // latch the mean once from the finished quotient
                        mean_reg <= neg_reg ? -$signed({1'b0, dquo_reg[DDW-1:0]})
                                            : $signed({1'b0, dquo_reg[DDW-1:0]});
                        dcnt_reg <= '0;
                    end
                    if (idx_reg == count_reg) begin
                        dnum_reg  <= dsum_reg;
                        drem_reg  <= '0;
                        state_reg <= S_DIV2;
                    end else begin
                        state_reg <= S_P2_SQ;
                    end
                end
                S_P2_SQ: begin
                    sq_reg    <= adev * adev;
                    state_reg <= S_P2_ACC;
                end
                S_P2_ACC: begin
                    dsum_reg  <= dsum_reg + DW'(prod2);
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_P2_RD;
                end
                S_ROOT: begin
                    if (rb_reg == '0) begin
                        if (mean_reg > (DDW+1)'(32767))
                            mean_o_reg <= 16'h7FFF;
                        else if (mean_reg < -(DDW+1)'(32768))
                            mean_o_reg <= 16'h8000;
                        else
                            mean_o_reg <= mean_reg[15:0];
                        std_o_reg <= (rr_reg > RW'(65535)) ? 16'hFFFF : rr_reg[15:0];
                        stat_reg  <= ovf_reg ? ST_TRUNC : ST_OK;
                        state_reg <= S_OUT;
                    end else begin
                        if ({1'b0, rv_reg} >= rtrial) begin
                            rv_reg <= rv_reg - rtrial[DW-1:0];
                            rr_reg <= (rr_reg >> 1) + RW'(rb_reg);
                        end else begin
                            rr_reg <= rr_reg >> 1;
                        end
                        rb_reg <= rb_reg >> 2;
                    end
                end
                S_OUT: if (!out_valid_reg || out_ready) begin
                    out_mean_reg <= mean_o_reg;
                    out_std_reg  <= std_o_reg;
                    out_stat_reg <= stat_reg;
                    count_reg    <= '0;
                    ovf_reg      <= 1'b0;
                    state_reg    <= S_LOAD;
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== rtl/weighted_mean_std_core.sv =====
// Top level of the weighted mean / standard deviation core.
// Depends on wms_pkg, wms_fifo and wms_back.
//
// Usage:
//   s_ channel: one sample/weight pair per transfer, tlast marks the final
//   pair of a vector. m_ channel: one result per vector (mean, std, status).
//   Pairs enter a four-entry queue, then the back end writes them into the
//   sample and weight memories, one pair a cycle while loading.
//   After the last pair the back end runs pass one over the stored pairs
//   (a read and an accumulate state per pair, one memory read port), a
//   bit-serial division (one bit a cycle), pass two (read, square and
//   accumulate states per pair), a second division and a bit-pair square root.
//   Input is held off meanwhile once the queue fills.
//   Pairs past MAX_ITEMS are dropped and status reports truncation.
//   Reset (aresetn low, synchronous) empties the queue and drops any vector.
//   While m_axis_tready is low the result holds in an output register and the
//   next vector loads and computes; the back end then waits with its result.
module weighted_mean_std_core #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] sample, [31:16] weight
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [15:0] mean, [31:16] std, [33:32] status
);
    import wms_pkg::*;

    pair_t       in_pair, q_pair;
    logic        q_valid, q_ready;
    logic [15:0] mean, stdv;
    logic [1:0]  status;

    // pack the transfer into the queue entry
    assign in_pair.sample  = s_axis_tdata[15:0];
    assign in_pair.weight  = s_axis_tdata[31:16];
    assign in_pair.is_last = s_axis_tlast;

    wms_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_pair),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_pair)
    );

    wms_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_data    (q_pair),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_mean   (mean),
        .out_std    (stdv),
        .out_status (status)
    );

    assign m_axis_tdata = {6'b0, status, stdv, mean};
endmodule
